>>> rtl/scpt_pkg.sv
package scpt_pkg;

  localparam int COORD_WIDTH = 22;
  localparam int LIMIT_W     = 21;
  localparam int CELL_W      = 44;
  localparam int CMP_W       = (COORD_WIDTH > LIMIT_W) ? COORD_WIDTH : LIMIT_W;
  localparam int CALC_W      = 2 * COORD_WIDTH + 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2000000);

  // trial divisor and its square
  localparam int CAND_W = CELL_W / 2 + 1;
  localparam int SQ_W   = 2 * CAND_W;
  localparam int REM_W  = CAND_W + 1;

  // remainder unit, bits of the dividend per cycle
  localparam int RADIX_BITS = 4;
  localparam int DIV_STEPS  = (CELL_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int DIVD_W     = DIV_STEPS * RADIX_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_AW + 2;

  typedef struct packed {
    logic [CELL_W-1:0] cell_number;
    logic              out_of_range;
  } queue_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } back_state_t;

  // candidate phase: 2, 3, then 6k-1 / 6k+1 alternating
  typedef enum logic [1:0] {
    PH_TWO,
    PH_THREE,
    PH_MINUS,
    PH_PLUS
  } cand_phase_t;

endpackage

>>> rtl/scpt_queue.sv
module scpt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  scpt_pkg::queue_entry_t push_entry,
  input  logic                  pop,
  output scpt_pkg::queue_entry_t pop_entry,
  output logic                  empty,
  output logic [scpt_pkg::Q_CNT_W-1:0] count
);
  import scpt_pkg::*;

  queue_entry_t        slots [QUEUE_DEPTH];
  logic [Q_AW-1:0]     wr_ptr;
  logic [Q_AW-1:0]     rd_ptr;
  logic [Q_CNT_W-1:0]  fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + Q_CNT_W'(1);
        2'b01:   fill <= fill - Q_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign pop_entry = slots[rd_ptr];
  assign empty     = (fill == '0);
  assign count     = fill;

endmodule

>>> rtl/scpt_front.sv
module scpt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [scpt_pkg::LIMIT_W-1:0]    cfg_data,
  input  logic                            start,
  input  logic signed [scpt_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [scpt_pkg::COORD_WIDTH-1:0] pos_y,
  input  logic [scpt_pkg::Q_CNT_W-1:0]    queue_count,
  output logic                            busy,
  output logic                            push,
  output scpt_pkg::queue_entry_t          push_entry
);
  import scpt_pkg::*;

  logic [LIMIT_W-1:0] coordinate_limit;

  // stage 1: magnitudes, ring and range check
  logic                          s1_valid;
  logic signed [COORD_WIDTH-1:0] s1_x, s1_y;
  logic [COORD_WIDTH-1:0]        s1_ax, s1_ay, s1_n;
  logic                          s1_oor;
  // stage 2: ring squared
  logic                          s2_valid;
  logic signed [COORD_WIDTH-1:0] s2_x, s2_y;
  logic [COORD_WIDTH-1:0]        s2_ax, s2_ay, s2_n;
  logic                          s2_oor;
  logic [2*COORD_WIDTH-1:0]      s2_nn;

  logic                   accept;
  logic [COORD_WIDTH-1:0] ax, ay;
  logic [Q_CNT_W-1:0]     pending;

  assign accept  = start && !busy;
  assign ax      = pos_x[COORD_WIDTH-1] ? $unsigned(-pos_x) : $unsigned(pos_x);
  assign ay      = pos_y[COORD_WIDTH-1] ? $unsigned(-pos_y) : $unsigned(pos_y);
  assign pending = queue_count + Q_CNT_W'(s1_valid) + Q_CNT_W'(s2_valid);
  assign busy    = (pending >= Q_CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      coordinate_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      coordinate_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x   <= pos_x;
    s1_y   <= pos_y;
    s1_ax  <= ax;
    s1_ay  <= ay;
    s1_n   <= (ax > ay) ? ax : ay;
    s1_oor <= (CMP_W'(ax) > CMP_W'(coordinate_limit)) ||
              (CMP_W'(ay) > CMP_W'(coordinate_limit));
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_ax  <= s1_ax;
    s2_ay  <= s1_ay;
    s2_n   <= s1_n;
    s2_oor <= s1_oor;
    s2_nn  <= s1_n * s1_n;
  end

  // side of the ring picks the closed formula
  logic signed [CALC_W-1:0] sx, sy, sn, base, top;
  logic signed [CALC_W-1:0] spiral;

  always_comb begin
    sx   = CALC_W'(s2_x);
    sy   = CALC_W'(s2_y);
    sn   = $signed(CALC_W'(s2_n));
    base = $signed(CALC_W'(s2_nn) << 2) - (sn <<< 2);
    top  = $signed(CALC_W'(s2_nn) << 2) + (sn <<< 2);
    if (s2_n == '0) begin
      spiral = '0;
    end else if (s2_ax == s2_ay) begin
      if (sx > 0 && sy < 0) begin
        spiral = top;
      end else if (sx > 0 && sy > 0) begin
        spiral = base + (sn <<< 1);
      end else if (sx < 0 && sy > 0) begin
        spiral = base + (sn <<< 2);
      end else begin
        spiral = base + (sn <<< 2) + (sn <<< 1);
      end
    end else if (s2_ax == s2_n) begin
      if (sx > 0) begin
        spiral = base + sn + sy;
      end else begin
        spiral = base + (sn <<< 2) + sn - sy;
      end
    end else if (sy > 0) begin
      spiral = base + (sn <<< 1) + sn - sx;
    end else begin
      spiral = top - sn + sx;
    end
  end

  assign push                    = s2_valid;
  assign push_entry.cell_number  = s2_oor ? '0 : spiral[CELL_W-1:0];
  assign push_entry.out_of_range = s2_oor;

endmodule

>>> rtl/scpt_back.sv
module scpt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         queue_empty,
  input  scpt_pkg::queue_entry_t       queue_entry,
  output logic                         pop,
  output logic                         done,
  output logic [scpt_pkg::CELL_W-1:0]  cell_number,
  output logic                         is_prime,
  output logic                         out_of_range
);
  import scpt_pkg::*;

  back_state_t          state, state_next;
  cand_phase_t          phase;
  logic [CELL_W-1:0]    value;
  logic [CAND_W-1:0]    cand;
  logic [SQ_W-1:0]      sq;
  logic [CAND_W-1:0]    rem;
  logic [DIVD_W-1:0]    dividend;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic emit, emit_prime, emit_oor;
  logic [CELL_W-1:0] emit_cell;
  logic load, start_div, advance;
  logic sq_over, div_last;
  logic [CAND_W-1:0] rem_step;
  logic [REM_W-1:0]  trial;

  assign sq_over  = (sq > SQ_W'(value));
  assign div_last = (div_cnt == DIV_CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!queue_empty && !queue_entry.out_of_range &&
            queue_entry.cell_number >= CELL_W'(2)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = sq_over ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = (rem_step == '0) ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // remainder step, RADIX_BITS dividend bits
  always_comb begin
    rem_step = rem;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial = {rem_step, dividend[DIVD_W-1-i]};
      if (trial >= REM_W'(cand)) begin
        trial = trial - REM_W'(cand);
      end
      rem_step = trial[CAND_W-1:0];
    end
  end

  // outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    emit_prime = 1'b0;
    emit_oor   = 1'b0;
    emit_cell  = value;
    load       = 1'b0;
    start_div  = 1'b0;
    advance    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!queue_empty) begin
          pop       = 1'b1;
          load      = 1'b1;
          emit_cell = queue_entry.cell_number;
          emit_oor  = queue_entry.out_of_range;
          emit      = queue_entry.out_of_range ||
                      (queue_entry.cell_number < CELL_W'(2));
        end
      end
      ST_CHECK: begin
        if (sq_over) begin
          emit       = 1'b1;
          emit_prime = 1'b1;
        end else begin
          start_div = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          if (rem_step == '0) begin
            emit = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_number  <= emit_cell;
      is_prime     <= emit_prime;
      out_of_range <= emit_oor;
    end
    if (load) begin
      value <= queue_entry.cell_number;
      cand  <= CAND_W'(2);
      sq    <= SQ_W'(4);
      phase <= PH_TWO;
    end
    if (start_div) begin
      rem      <= '0;
      dividend <= DIVD_W'(value) << (DIVD_W - CELL_W);
      div_cnt  <= DIV_CNT_W'(DIV_STEPS);
    end
    if (state == ST_DIV) begin
      rem      <= rem_step;
      dividend <= dividend << RADIX_BITS;
      div_cnt  <= div_cnt - DIV_CNT_W'(1);
    end
    if (advance) begin
      case (phase)
        PH_TWO: begin
          cand  <= cand + CAND_W'(1);
          sq    <= sq + (SQ_W'(cand) << 1) + SQ_W'(1);
          phase <= PH_THREE;
        end
        PH_THREE: begin
          cand  <= cand + CAND_W'(2);
          sq    <= sq + (SQ_W'(cand) << 2) + SQ_W'(4);
          phase <= PH_MINUS;
        end
        PH_MINUS: begin
          cand  <= cand + CAND_W'(2);
          sq    <= sq + (SQ_W'(cand) << 2) + SQ_W'(4);
          phase <= PH_PLUS;
        end
        // 6k+1 -> 6k+5
        PH_PLUS: begin
          cand  <= cand + CAND_W'(4);
          sq    <= sq + (SQ_W'(cand) << 3) + SQ_W'(16);
          phase <= PH_MINUS;
        end
        default: phase <= PH_MINUS;
      endcase
    end
  end

  a_prime_in_range: assert property (@(posedge clk) disable iff (rst)
    done && is_prime |-> !out_of_range && cell_number >= CELL_W'(2))
    else $error("prime flagged on invalid cell");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> cell_number == '0 && !is_prime)
    else $error("out of range result carries a cell number");

  a_div_cand: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cand >= CAND_W'(2))
    else $error("trial divisor below two");

endmodule

>>> rtl/spiral_cell_prime_test.sv
// Ulam spiral cell number and primality test. Pulse start with pos_x/pos_y
// while busy is low; the request is taken at that edge. The front end takes a
// request per cycle while busy is low into a four-entry queue (busy is high
// while the queue and the two front stages together hold four requests); the
// spiral number passes through both front stages into the queue.
// The back end then works one request at a time: out-of-range coordinates and
// cells below two leave it straight from the idle state with no division;
// otherwise it tries divisors 2, 3 and then every 6k-1 / 6k+1 while the
// divisor squared is at most the cell, each after a bound check and each
// remainder on a shared radix-16 remainder unit. Every result shows up for
// exactly one cycle with done high, in request order; the receiver cannot
// stall, so it must take each result when done is seen. The user must write
// coordinate_limit through cfg_write/cfg_data only while idle; the block
// itself does not enforce this.
module spiral_cell_prime_test (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic [scpt_pkg::LIMIT_W-1:0]           cfg_data,
  // request side
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [scpt_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [scpt_pkg::COORD_WIDTH-1:0] pos_y,
  // result side
  output logic                                   done,
  output logic [scpt_pkg::CELL_W-1:0]            cell_number,
  output logic                                   is_prime,
  output logic                                   out_of_range
);
  import scpt_pkg::*;

  logic               push, pop, queue_empty;
  queue_entry_t       push_entry, pop_entry;
  logic [Q_CNT_W-1:0] queue_count;

  // range check and spiral formula
  scpt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .start       (start),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .queue_count (queue_count),
    .busy        (busy),
    .push        (push),
    .push_entry  (push_entry)
  );

  // decouples the fast front from the trial division
  scpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (queue_empty),
    .count      (queue_count)
  );

  // trial division and result register
  scpt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .queue_entry  (pop_entry),
    .pop          (pop),
    .done         (done),
    .cell_number  (cell_number),
    .is_prime     (is_prime),
    .out_of_range (out_of_range)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;
  import scpt_pkg::*;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [LIMIT_W-1:0] cfg_data;
  logic start;
  logic busy;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic done;
  logic [CELL_W-1:0] cell_number;
  logic is_prime;
  logic out_of_range;

  // one spiral cell result as the block reports it
  typedef struct {
    logic [CELL_W-1:0] cell_num;
    logic              prime;
    logic              oor;
  } cell_result_t;

  // directed request, with the result typed in where it is obvious
  typedef struct {
    int          x;
    int          y;
    bit          typed;
    longint      cell_num;
    bit          prime;
    bit          oor;
  } directed_row_t;

  cell_result_t pending_cells[$];
  logic [LIMIT_W-1:0] limit_now;
  int mismatches;
  longint cycles;

  spiral_cell_prime_test dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .done         (done),
    .cell_number  (cell_number),
    .is_prime     (is_prime),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // square spiral number, origin is zero
  function automatic longint spiral_index(longint x, longint y);
    longint ax, ay, n, base;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    n = (ax > ay) ? ax : ay;
    base = 4 * n * (n - 1);
    if (n == 0) return 0;
    if (ax == ay) begin
      if (x > 0 && y < 0) return 4 * n * (n + 1);
      if (x > 0 && y > 0) return base + 2 * n;
      if (x < 0 && y > 0) return base + 4 * n;
      return base + 6 * n;
    end
    if (ax == n) begin
      if (x > 0) return base + 2 * n - (n - y);
      return base + 4 * n + (n - y);
    end
    if (y > 0) return base + 2 * n + (n - x);
    return 4 * n * (n + 1) - (n - x);
  endfunction

  // trial division over 2, 3 and the 6k-1 / 6k+1 candidates
  function automatic bit prime_by_trial(longint v);
    longint d;
    if (v < 2) return 1'b0;
    if (v == 2 || v == 3) return 1'b1;
    if (v % 2 == 0 || v % 3 == 0) return 1'b0;
    for (d = 5; d * d <= v; d += 6) begin
      if (v % d == 0) return 1'b0;
      if ((d + 2) * (d + 2) <= v && v % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cell_result_t predict_cell(longint x, longint y);
    cell_result_t r;
    longint ax, ay;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax > longint'(limit_now) || ay > longint'(limit_now)) begin
      r.cell_num = '0;
      r.prime = 1'b0;
      r.oor = 1'b1;
    end else begin
      r.cell_num = CELL_W'(spiral_index(x, y));
      r.prime = prime_by_trial(spiral_index(x, y));
      r.oor = 1'b0;
    end
    return r;
  endfunction

  // result checker: the receiver never stalls, so every done pulse is a result
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && done) begin
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result cell=%0d prime=%0b oor=%0b",
                   cell_number, is_prime, out_of_range);
      end else begin
        want = pending_cells.pop_front();
        if (cell_number !== want.cell_num || is_prime !== want.prime ||
            out_of_range !== want.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cell=%0d prime=%0b oor=%0b, got cell=%0d prime=%0b oor=%0b",
                     want.cell_num, want.prime, want.oor, cell_number, is_prime,
                     out_of_range);
        end
      end
    end
  end

  // watchdog, sized for small random cells and the directed rows
  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd4000000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // hold start until the request is taken, then idle for a while at random
  task automatic send_request(longint x, longint y, bit may_idle, bit typed,
                              cell_result_t typed_res);
    cell_result_t r;
    int gap;
    start <= 1'b1;
    pos_x <= COORD_WIDTH'(x);
    pos_y <= COORD_WIDTH'(y);
    do @(posedge clk); while (busy);
    r = predict_cell(x, y);
    // directed rows with a typed result are checked against the typed values
    if (typed && (r.cell_num !== typed_res.cell_num || r.prime !== typed_res.prime ||
                  r.oor !== typed_res.oor)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("typed row (%0d,%0d) disagrees with prediction", x, y);
    end
    pending_cells.push_back(typed ? typed_res : r);
    if (may_idle && $urandom_range(99) < 21) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait out every result, then let the back end settle before a write
  task automatic drain_and_write(logic [LIMIT_W-1:0] value);
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_now = value;
  endtask

  function automatic longint full_coord();
    logic signed [COORD_WIDTH-1:0] v;
    v = COORD_WIDTH'($urandom);
    return longint'(v);
  endfunction

  directed_row_t rows[$];
  cell_result_t typed_res;

  initial begin
    mismatches = 0;
    cycles = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    pos_x = '0;
    pos_y = '0;
    limit_now = LIMIT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // origin and the first ring, one cell per corner and side, plus one untyped cell
    rows.push_back('{0, 0, 1, 0, 0, 0});
    rows.push_back('{1, 0, 1, 1, 0, 0});
    rows.push_back('{1, 1, 1, 2, 1, 0});
    rows.push_back('{0, 1, 1, 3, 1, 0});
    rows.push_back('{-1, 1, 1, 4, 0, 0});
    rows.push_back('{-1, 0, 1, 5, 1, 0});
    rows.push_back('{-1, -1, 1, 6, 0, 0});
    rows.push_back('{0, -1, 1, 7, 1, 0});
    rows.push_back('{1, -1, 1, 8, 0, 0});
    rows.push_back('{3, 2, 0, 0, 0, 0});
    // outer ring at the limit: all even, so the division ends early
    rows.push_back('{2000000, -2000000, 0, 0, 0, 0});
    rows.push_back('{2000000, 2000000, 0, 0, 0, 0});
    rows.push_back('{-2000000, 2000000, 0, 0, 0, 0});
    rows.push_back('{-2000000, -2000000, 0, 0, 0, 0});
    rows.push_back('{2000000, 4, 0, 0, 0, 0});
    rows.push_back('{-2000000, 4, 0, 0, 0, 0});
    rows.push_back('{4, 2000000, 0, 0, 0, 0});
    rows.push_back('{4, -2000000, 0, 0, 0, 0});
    // just past the limit and the field extremes
    rows.push_back('{2000001, 0, 1, 0, 0, 1});
    rows.push_back('{0, -2000001, 1, 0, 0, 1});
    rows.push_back('{-2097152, 0, 1, 0, 0, 1});
    rows.push_back('{0, 2097151, 1, 0, 0, 1});
    rows.push_back('{-2097152, -2097152, 1, 0, 0, 1});
    rows.push_back('{2097151, 2097151, 1, 0, 0, 1});
    foreach (rows[i]) begin
      typed_res.cell_num = CELL_W'(rows[i].cell_num);
      typed_res.prime = rows[i].prime;
      typed_res.oor = rows[i].oor;
      send_request(rows[i].x, rows[i].y, 1'b1, rows[i].typed, typed_res);
    end

    // small coordinates at the reset limit, back to back in the middle
    for (int i = 0; i < 24; i++)
      send_request($signed($urandom_range(600)) - 300,
                   $signed($urandom_range(600)) - 300,
                   !(i >= 4 && i < 20), 1'b0, typed_res);

    // mid limit: small cells and full-width noise that falls outside
    drain_and_write(LIMIT_W'(1000));
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(99) < 70)
        send_request($signed($urandom_range(600)) - 300,
                     $signed($urandom_range(600)) - 300, 1'b1, 1'b0, typed_res);
      else
        send_request(full_coord(), full_coord(), 1'b1, 1'b0, typed_res);
    end

    // zero limit: only the origin stays in range
    drain_and_write('0);
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 0)
        send_request(0, 0, 1'b1, 1'b0, typed_res);
      else if (i % 4 == 1)
        send_request($signed($urandom_range(2)) - 1,
                     $signed($urandom_range(2)) - 1, 1'b1, 1'b0, typed_res);
      else
        send_request(full_coord(), full_coord(), 1'b1, 1'b0, typed_res);
    end

    // top limit again
    drain_and_write(LIMIT_W'(2000000));
    for (int i = 0; i < 20; i++)
      send_request($signed($urandom_range(400)) - 200,
                   $signed($urandom_range(400)) - 200, 1'b1, 1'b0, typed_res);

    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> spiral_cell_prime_test.f
rtl/scpt_pkg.sv
rtl/scpt_queue.sv
rtl/scpt_front.sv
rtl/scpt_back.sv
rtl/spiral_cell_prime_test.sv
tb/tb_top.sv
